// ===== hw/rtl/dht_pkg.sv =====
// Shared constants, codes and types of the double-hashing table engine.
package dht_pkg;

  // Table geometry and field widths.
  localparam int unsigned TableDepth = 64;
  localparam int unsigned SlotAw     = $clog2(TableDepth);
  localparam int unsigned KeyW       = 31;
  localparam int unsigned SizeW      = 7;
  localparam int unsigned FuncW      = 2;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned SlotIdxW   = 6;

  // Size register value after reset.
  localparam logic [SizeW-1:0] SizeReset = SizeW'(13);

  // Second hash is HashPrime - key mod HashPrime.
  localparam int unsigned HashPrime = 7;
  localparam int unsigned Rem7W     = $clog2(HashPrime);

  // Remainder unit: DigitW key bits are taken per cycle.
  localparam int unsigned DigitW   = 4;
  localparam int unsigned ModSteps = (KeyW + DigitW - 1) / DigitW;
  localparam int unsigned ModPadW  = ModSteps * DigitW;
  localparam int unsigned ModCntW  = $clog2(ModSteps);

  // Operation codes.
  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_REMOVE = 2'd2
  } dht_func_e;

  // Per-slot status.
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } dht_slot_e;

  // Result codes.
  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOSLOT   = 3'd3,
    ST_FOUND    = 3'd4,
    ST_MISSING  = 3'd5,
    ST_REMOVED  = 3'd6
  } dht_status_e;

  // Home slot and key mod HashPrime from the remainder unit.
  typedef struct packed {
    logic [SlotAw-1:0] home;
    logic [Rem7W-1:0]  rem7;
  } dht_hash_t;

  // One table entry as held in the slot memory.
  typedef struct packed {
    dht_slot_e       state;
    logic [KeyW-1:0] key;
  } dht_entry_t;

  localparam int unsigned EntryW = $bits(dht_entry_t);

endpackage

// ===== hw/rtl/dht_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dht_mod_unit.sv =====
// Digit-serial remainder unit: key mod table size and key mod the hash prime.
module dht_mod_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dht_pkg::KeyW-1:0]  key_i,
  input  logic [dht_pkg::SizeW-1:0] size_i,
  output logic                      done_o,
  output dht_pkg::dht_hash_t        hash_o
);
  import dht_pkg::*;

  logic               running_q, running_d;
  logic               done_q, done_d;
  logic [ModCntW-1:0] cnt_q, cnt_d;
  logic [ModPadW-1:0] dig_q, dig_d;
  logic [SlotAw-1:0]  remn_q, remn_d;
  logic [Rem7W-1:0]   rem7_q, rem7_d;
  logic [SizeW-1:0]   rn;
  logic [Rem7W:0]     r7;

  // One digit of restoring reduction for both moduli, most significant bit first.
  always_comb begin
    rn = SizeW'(remn_q);
    r7 = (Rem7W+1)'(rem7_q);
    for (int b = 0; b < DigitW; b++) begin
      rn = {rn[SizeW-2:0], dig_q[ModPadW-1-b]};
      if (rn >= size_i) begin
        rn = rn - size_i;
      end
      r7 = {r7[Rem7W-1:0], dig_q[ModPadW-1-b]};
      if (r7 >= (Rem7W+1)'(HashPrime)) begin
        r7 = r7 - (Rem7W+1)'(HashPrime);
      end
    end
  end

  // Sequencing of the digit steps.
  always_comb begin
    running_d = running_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    dig_d     = dig_q;
    remn_d    = remn_q;
    rem7_d    = rem7_q;
    if (start_i) begin
      running_d = 1'b1;
      cnt_d     = '0;
      dig_d     = {{(ModPadW-KeyW){1'b0}}, key_i};
      remn_d    = '0;
      rem7_d    = '0;
    end else if (running_q) begin
      dig_d  = {dig_q[ModPadW-DigitW-1:0], {DigitW{1'b0}}};
      remn_d = rn[SlotAw-1:0];
      rem7_d = r7[Rem7W-1:0];
      cnt_d  = cnt_q + ModCntW'(1);
      if (cnt_q == ModCntW'(ModSteps - 1)) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    remn_q <= remn_d;
    rem7_q <= rem7_d;
  end

  assign done_o      = done_q;
  assign hash_o.home = remn_q;
  assign hash_o.rem7 = rem7_q;

endmodule

// ===== hw/rtl/double_hash_table_engine_core.sv =====
// Double-hashing hash table engine: top level with the probe sequencer.
//
// Each item (start_i high while busy_o is low) inserts, searches for or removes one
// key and yields exactly one result, shown for a single cycle with done_o high; the
// receiver cannot stall, so it must take the result in that cycle. An insert into a
// full table and an unused operation code answer in the cycle after acceptance, and the
// block stays idle for them. Every other item first passes through the remainder unit,
// which takes four key bits a cycle, and then through one probe after another (one
// memory read, one check and possible write back) until it is settled. busy_o is low
// during the result cycle, so a new item may be accepted there. The table size register
// (cfg_data_i) is written through cfg_valid_i, which is always ready; it should change
// only while the block is idle. Slot keys live in one synchronous memory; per-slot valid
// flags cleared at reset make every slot read as empty, so no clearing pass is needed.
module double_hash_table_engine_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [dht_pkg::FuncW-1:0]   func_i,
  input  logic [dht_pkg::KeyW-1:0]    key_i,
  output logic                        done_o,
  output logic [dht_pkg::StatusW-1:0] status_o,
  output logic [dht_pkg::SlotIdxW-1:0] slot_index_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dht_pkg::SizeW-1:0]   cfg_data_i
);
  import dht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_PROBE = 4'b0100,
    S_CHECK = 4'b1000
  } dht_state_e;

  dht_state_e        state_q, state_d;
  dht_func_e         func_q, func_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [SizeW-1:0]  size_q;
  logic [SizeW-1:0]  used_q, used_d;
  logic [SlotAw-1:0] slot_q, slot_d;
  logic [Rem7W-1:0]  stepm_q, stepm_d;
  logic [SlotAw-1:0] idx_q, idx_d;
  logic [TableDepth-1:0] valid_q, valid_d;
  logic              done_q, done_d;
  dht_status_e       status_q, status_d;
  logic [SlotAw-1:0] res_slot_q, res_slot_d;

  logic [SizeW-1:0]  n_eff;
  logic              mod_start;
  logic              mod_done;
  dht_hash_t         mod_hash;
  logic [SizeW-1:0]  step_r;
  logic [SizeW-1:0]  sum;
  logic [SlotAw-1:0] slot_next;
  logic              last_probe;
  logic [EntryW-1:0] ram_rdata;
  dht_entry_t        entry;
  logic              key_match;
  logic              wr_en;
  dht_entry_t        wr_entry;

  // Effective table size: zero acts as one, anything above the depth as the depth.
  always_comb begin
    n_eff = size_q;
    if (size_q == '0) begin
      n_eff = SizeW'(1);
    end else if (size_q > SizeW'(TableDepth)) begin
      n_eff = SizeW'(TableDepth);
    end
  end

  // Remainder unit for the home slot and the step. It samples the key on the edge
  // that accepts the item, so it takes the key straight from the input port.
  dht_mod_unit u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (key_i),
    .size_i  (n_eff),
    .done_o  (mod_done),
    .hash_o  (mod_hash)
  );

  // Step reduced modulo the table size; the step is at most the hash prime.
  always_comb begin
    step_r = SizeW'(HashPrime) - SizeW'(mod_hash.rem7);
    for (int k = 0; k < HashPrime; k++) begin
      if (step_r >= n_eff) begin
        step_r = step_r - n_eff;
      end
    end
  end

  // Next slot in the probe sequence and the last-probe test.
  always_comb begin
    sum = SizeW'(slot_q) + SizeW'(stepm_q);
    if (sum >= n_eff) begin
      sum = sum - n_eff;
    end
    slot_next  = sum[SlotAw-1:0];
    last_probe = (SizeW'(idx_q) + SizeW'(1)) == n_eff;
  end

  // Slot memory: state and key of every written slot.
  dht_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (slot_q),
    .wdata_i (wr_entry),
    .re_i    (state_q == S_PROBE),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // A slot never written since reset reads as empty.
  always_comb begin
    entry = dht_entry_t'(ram_rdata);
    if (!valid_q[slot_q]) begin
      entry.state = SLOT_EMPTY;
    end
    key_match = (entry.state == SLOT_USED) && (entry.key == key_q);
  end

  // Sequencer: accept, hash, then read and check one slot after another.
  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    key_d      = key_q;
    used_d     = used_q;
    slot_d     = slot_q;
    stepm_d    = stepm_q;
    idx_d      = idx_q;
    valid_d    = valid_q;
    done_d     = 1'b0;
    status_d   = status_q;
    res_slot_d = res_slot_q;
    mod_start  = 1'b0;
    wr_en      = 1'b0;
    wr_entry   = entry;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d = dht_func_e'(func_i);
          key_d  = key_i;
          unique case (dht_func_e'(func_i)) inside
            FUNC_INSERT: begin
              if (used_q >= n_eff) begin
                done_d     = 1'b1;
                status_d   = ST_FULL;
                res_slot_d = '0;
              end else begin
                state_d = S_HASH;
              end
            end
            FUNC_SEARCH, FUNC_REMOVE: begin
              state_d = S_HASH;
            end
            default: begin
              done_d     = 1'b1;
              status_d   = ST_MISSING;
              res_slot_d = '0;
            end
          endcase
        end
      end

      S_HASH: begin
        if (mod_done) begin
          slot_d  = mod_hash.home;
          stepm_d = step_r[Rem7W-1:0];
          idx_d   = '0;
          state_d = S_PROBE;
        end
      end

      S_PROBE: begin
        state_d = S_CHECK;
      end

      S_CHECK: begin
        state_d = S_PROBE;
        slot_d  = slot_next;
        idx_d   = idx_q + SlotAw'(1);
        if (func_q == FUNC_INSERT) begin
          if (key_match) begin
            done_d     = 1'b1;
            status_d   = ST_PRESENT;
            res_slot_d = slot_q;
            state_d    = S_IDLE;
          end else if (entry.state != SLOT_USED) begin
            wr_en           = 1'b1;
            wr_entry.state  = SLOT_USED;
            wr_entry.key    = key_q;
            valid_d[slot_q] = 1'b1;
            used_d          = used_q + SizeW'(1);
            done_d          = 1'b1;
            status_d        = ST_INSERTED;
            res_slot_d      = slot_q;
            state_d         = S_IDLE;
          end else if (last_probe) begin
            done_d     = 1'b1;
            status_d   = ST_NOSLOT;
            res_slot_d = '0;
            state_d    = S_IDLE;
          end
        end else begin
          if (entry.state == SLOT_EMPTY) begin
            done_d     = 1'b1;
            status_d   = ST_MISSING;
            res_slot_d = '0;
            state_d    = S_IDLE;
          end else if (key_match) begin
            done_d     = 1'b1;
            res_slot_d = slot_q;
            state_d    = S_IDLE;
            if (func_q == FUNC_REMOVE) begin
              wr_en           = 1'b1;
              wr_entry.state  = SLOT_TOMB;
              wr_entry.key    = key_q;
              valid_d[slot_q] = 1'b1;
              if (used_q != '0) begin
                used_d = used_q - SizeW'(1);
              end
              status_d = ST_REMOVED;
            end else begin
              status_d = ST_FOUND;
            end
          end else if (last_probe) begin
            done_d     = 1'b1;
            status_d   = ST_MISSING;
            res_slot_d = '0;
            state_d    = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // The remainder unit starts on the edge that moves into hashing.
    if (state_q == S_IDLE && state_d == S_HASH) begin
      mod_start = 1'b1;
      key_d     = key_i;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      valid_q  <= '0;
      done_q   <= 1'b0;
      size_q   <= SizeReset;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      valid_q <= valid_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_data_i;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    key_q      <= key_d;
    slot_q     <= slot_d;
    stepm_q    <= stepm_d;
    idx_q      <= idx_d;
    status_q   <= status_d;
    res_slot_q <= res_slot_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_index_o = SlotIdxW'(res_slot_q);

endmodule
